/* rtl/tmfs_pkg.sv */
// Shared widths, status codes and result type for the triangle metrics block.
package tmfs_pkg;

    localparam int SIDE_W   = 34;
    localparam int PERIM_W  = 36;
    localparam int AREA_W   = 50;
    localparam int METRIC_W = 34;
    localparam int STATUS_W = 2;
    // low-part width used to cut wide products into partial products
    localparam int SPLIT_W  = 35;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHAPE = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PERIM_W-1:0]  perimeter;
        logic [AREA_W-1:0]   area;
        logic [METRIC_W-1:0] height_a;
        logic [METRIC_W-1:0] height_b;
        logic [METRIC_W-1:0] height_c;
        logic [METRIC_W-1:0] median_a;
        logic [METRIC_W-1:0] median_b;
        logic [METRIC_W-1:0] median_c;
        logic [METRIC_W-1:0] bisector_a;
        logic [METRIC_W-1:0] bisector_b;
        logic [METRIC_W-1:0] bisector_c;
    } t_result;

endpackage

/* rtl/tmfs_if.sv */
// Valid/ready channel interfaces for side items and metric items.
interface tmfs_in_if;
    logic                         valid;
    logic                         ready;
    logic [tmfs_pkg::SIDE_W-1:0]  side_a;
    logic [tmfs_pkg::SIDE_W-1:0]  side_b;
    logic [tmfs_pkg::SIDE_W-1:0]  side_c;

    modport source (output valid, output side_a, output side_b, output side_c, input ready);
    modport sink   (input valid, input side_a, input side_b, input side_c, output ready);
endinterface

interface tmfs_out_if;
    logic                          valid;
    logic                          ready;
    logic [tmfs_pkg::STATUS_W-1:0] status;
    logic [tmfs_pkg::PERIM_W-1:0]  perimeter;
    logic [tmfs_pkg::AREA_W-1:0]   area;
    logic [tmfs_pkg::METRIC_W-1:0] height_a;
    logic [tmfs_pkg::METRIC_W-1:0] height_b;
    logic [tmfs_pkg::METRIC_W-1:0] height_c;
    logic [tmfs_pkg::METRIC_W-1:0] median_a;
    logic [tmfs_pkg::METRIC_W-1:0] median_b;
    logic [tmfs_pkg::METRIC_W-1:0] median_c;
    logic [tmfs_pkg::METRIC_W-1:0] bisector_a;
    logic [tmfs_pkg::METRIC_W-1:0] bisector_b;
    logic [tmfs_pkg::METRIC_W-1:0] bisector_c;

    modport source (output valid, output status, output perimeter, output area,
                    output height_a, output height_b, output height_c,
                    output median_a, output median_b, output median_c,
                    output bisector_a, output bisector_b, output bisector_c,
                    input ready);
    modport sink   (input valid, input status, input perimeter, input area,
                    input height_a, input height_b, input height_c,
                    input median_a, input median_b, input median_c,
                    input bisector_a, input bisector_b, input bisector_c,
                    output ready);
endinterface

/* rtl/triangle_metrics_from_sides.sv */
// Top level: triangle perimeter, area, heights, medians and bisectors from three sides.
// The result path runs through 4 front stages, a 70-stage bisector square root and a
// 34-stage divider; this longest path sets the pipeline depth.
// Throughput: one item per cycle while not stalled; every unit is fully pipelined with one shared enable.
// A one-entry skid buffer holds a result the sink refuses; the pipe stalls while it is full.
// Reset (synchronous, active low) clears the valid bits and the skid buffer only.
module triangle_metrics_from_sides #(
    parameter int FRAC_BITS = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tmfs_in_if.sink           i_in,
    tmfs_out_if.source        o_out
);

    localparam int SIDE_W      = tmfs_pkg::SIDE_W;
    localparam int AREA_W      = tmfs_pkg::AREA_W;
    localparam int STATUS_W    = tmfs_pkg::STATUS_W;
    localparam int QUO_W       = tmfs_pkg::METRIC_W;
    localparam int SUM_W       = SIDE_W + 1;
    localparam int X_W         = SIDE_W + 2;
    localparam int SQ_W        = 2 * SIDE_W;
    localparam int XY_W        = X_W + SUM_W;
    localparam int ZW_W        = 2 * SUM_W;
    localparam int P_W         = XY_W + ZW_W;
    localparam int BN_W        = SQ_W + XY_W;
    localparam int BIS_RAD_W   = BN_W + (BN_W % 2);
    localparam int BIS_ROOT_W  = BIS_RAD_W / 2;
    localparam int MQ_W        = SQ_W + 2;
    localparam int MED_RAD_W   = SQ_W;
    localparam int MED_ROOT_W  = SQ_W / 2;
    localparam int AREA_SH     = 2 * FRAC_BITS + 4;
    localparam int AREA_RAD_R  = P_W - AREA_SH;
    localparam int AREA_RAD_W  = AREA_RAD_R + (AREA_RAD_R % 2);
    localparam int AREA_ROOT_W = AREA_RAD_W / 2;
    localparam int HNUM_W      = AREA_ROOT_W + FRAC_BITS + 1;
    localparam int LAT         = 4 + BIS_ROOT_W + QUO_W;
    localparam int AREA_PAD    = BIS_ROOT_W - AREA_ROOT_W;
    localparam int MED_PAD     = BIS_ROOT_W + QUO_W - MED_ROOT_W;
    localparam int SIDE_DLY    = 3 + BIS_ROOT_W;
    localparam int STAT_DLY    = LAT - 1;
    localparam int SB_W        = 3 * SIDE_W + 3 * SUM_W;
    localparam logic [63:0] MIN_RAW = 64'(((2 ** FRAC_BITS) + 99999) / 100000);
    localparam logic [63:0] MAX_RAW = 64'(100000) << FRAC_BITS;

    // pipeline control
    logic                  w_en;
    logic                  w_accept;
    logic [LAT-1:0]        r_vld;
    logic                  r_skid_vld;
    tmfs_pkg::t_result     r_skid;
    tmfs_pkg::t_result     w_final;
    tmfs_pkg::t_result     w_out;

    // front stage
    logic                  w_rng_bad;
    logic                  w_shape_bad;
    logic [SUM_W-1:0]      w_ab, w_ac, w_bc;
    logic [STATUS_W-1:0]   n1_status;
    logic [STATUS_W-1:0]   r1_status;
    logic [SIDE_W-1:0]     r1_a, r1_b, r1_c;
    logic [X_W-1:0]        r1_x;
    logic [SUM_W-1:0]      r1_y, r1_z, r1_w;
    logic [SUM_W-1:0]      r1_sab, r1_sac, r1_sbc;

    // product stage
    logic [XY_W-1:0]       r2_xy, r2_xz, r2_xw;
    logic [ZW_W-1:0]       r2_zw;
    logic [SQ_W-1:0]       r2_bc, r2_ac, r2_ab;
    logic [SQ_W-1:0]       r2_aa, r2_bb, r2_cc;

    logic [MQ_W-1:0]       w_qa, w_qb, w_qc;
    logic [MQ_W-1:0]       w_qa_d, w_qb_d, w_qc_d;
    logic [P_W-1:0]        w_heron;
    logic [BN_W-1:0]       w_bn_a, w_bn_b, w_bn_c;

    logic [MED_ROOT_W-1:0] w_mr_a, w_mr_b, w_mr_c;
    logic [MED_ROOT_W-1:0] w_med_a, w_med_b, w_med_c;
    logic [AREA_ROOT_W-1:0] w_area_root, w_area_pad, w_area_end;
    logic [BIS_ROOT_W-1:0] w_br_a, w_br_b, w_br_c;
    logic [QUO_W-1:0]      w_bis_a, w_bis_b, w_bis_c;
    logic [QUO_W-1:0]      w_hgt_a, w_hgt_b, w_hgt_c;
    logic [HNUM_W-1:0]     w_hnum;

    logic [SIDE_W-1:0]     w_sa, w_sb, w_sc;
    logic [SUM_W-1:0]      w_ssab, w_ssac, w_ssbc;
    logic [STATUS_W-1:0]   w_status_end;
    logic [X_W-1:0]        w_perim_end;

    // stall the whole pipe while the skid buffer holds a result
    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;
    assign w_accept   = i_in.valid && w_en;

    // range and triangle checks, side sums
    always_comb begin
        w_ab = SUM_W'(i_in.side_a) + SUM_W'(i_in.side_b);
        w_ac = SUM_W'(i_in.side_a) + SUM_W'(i_in.side_c);
        w_bc = SUM_W'(i_in.side_b) + SUM_W'(i_in.side_c);
        w_rng_bad = (64'(i_in.side_a) < MIN_RAW) || (64'(i_in.side_b) < MIN_RAW)
                 || (64'(i_in.side_c) < MIN_RAW) || (64'(i_in.side_a) > MAX_RAW)
                 || (64'(i_in.side_b) > MAX_RAW) || (64'(i_in.side_c) > MAX_RAW);
        w_shape_bad = (w_ab <= SUM_W'(i_in.side_c)) || (w_ac <= SUM_W'(i_in.side_b))
                   || (w_bc <= SUM_W'(i_in.side_a));
        if (w_rng_bad) begin
            n1_status = tmfs_pkg::ST_RANGE;
        end else if (w_shape_bad) begin
            n1_status = tmfs_pkg::ST_SHAPE;
        end else begin
            n1_status = tmfs_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_status <= n1_status;
            r1_a      <= i_in.side_a;
            r1_b      <= i_in.side_b;
            r1_c      <= i_in.side_c;
            r1_x      <= X_W'(i_in.side_a) + X_W'(i_in.side_b) + X_W'(i_in.side_c);
            r1_y      <= w_bc - SUM_W'(i_in.side_a);
            r1_z      <= w_ac - SUM_W'(i_in.side_b);
            r1_w      <= w_ab - SUM_W'(i_in.side_c);
            r1_sab    <= w_ab;
            r1_sac    <= w_ac;
            r1_sbc    <= w_bc;
        end
    end

    // pairwise products and squares
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_xy <= XY_W'(r1_x) * XY_W'(r1_y);
            r2_xz <= XY_W'(r1_x) * XY_W'(r1_z);
            r2_xw <= XY_W'(r1_x) * XY_W'(r1_w);
            r2_zw <= ZW_W'(r1_z) * ZW_W'(r1_w);
            r2_bc <= SQ_W'(r1_b) * SQ_W'(r1_c);
            r2_ac <= SQ_W'(r1_a) * SQ_W'(r1_c);
            r2_ab <= SQ_W'(r1_a) * SQ_W'(r1_b);
            r2_aa <= SQ_W'(r1_a) * SQ_W'(r1_a);
            r2_bb <= SQ_W'(r1_b) * SQ_W'(r1_b);
            r2_cc <= SQ_W'(r1_c) * SQ_W'(r1_c);
        end
    end

    // median radicands 2s1^2 + 2s2^2 - opp^2
    always_comb begin
        w_qa = ((MQ_W'(r2_bb) + MQ_W'(r2_cc)) << 1) - MQ_W'(r2_aa);
        w_qb = ((MQ_W'(r2_aa) + MQ_W'(r2_cc)) << 1) - MQ_W'(r2_bb);
        w_qc = ((MQ_W'(r2_aa) + MQ_W'(r2_bb)) << 1) - MQ_W'(r2_cc);
    end

    tmfs_delay #(.W(3 * MQ_W), .DEPTH(2)) u_q_dly (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({w_qa, w_qb, w_qc}), .o_q({w_qa_d, w_qb_d, w_qc_d})
    );

    // wide products: Heron radicand and bisector radicands
    tmfs_wmul #(.A_W(XY_W), .B_W(ZW_W)) u_heron (
        .i_clk(i_clk), .i_en(w_en), .i_a(r2_xy), .i_b(r2_zw), .o_p(w_heron)
    );
    tmfs_wmul #(.A_W(SQ_W), .B_W(XY_W)) u_bn_a (
        .i_clk(i_clk), .i_en(w_en), .i_a(r2_bc), .i_b(r2_xy), .o_p(w_bn_a)
    );
    tmfs_wmul #(.A_W(SQ_W), .B_W(XY_W)) u_bn_b (
        .i_clk(i_clk), .i_en(w_en), .i_a(r2_ac), .i_b(r2_xz), .o_p(w_bn_b)
    );
    tmfs_wmul #(.A_W(SQ_W), .B_W(XY_W)) u_bn_c (
        .i_clk(i_clk), .i_en(w_en), .i_a(r2_ab), .i_b(r2_xw), .o_p(w_bn_c)
    );

    // medians: root of a quarter of the radicand
    tmfs_isqrt #(.RAD_W(MED_RAD_W)) u_med_a (
        .i_clk(i_clk), .i_en(w_en), .i_rad(w_qa_d[MQ_W-1:2]), .o_root(w_mr_a)
    );
    tmfs_isqrt #(.RAD_W(MED_RAD_W)) u_med_b (
        .i_clk(i_clk), .i_en(w_en), .i_rad(w_qb_d[MQ_W-1:2]), .o_root(w_mr_b)
    );
    tmfs_isqrt #(.RAD_W(MED_RAD_W)) u_med_c (
        .i_clk(i_clk), .i_en(w_en), .i_rad(w_qc_d[MQ_W-1:2]), .o_root(w_mr_c)
    );
    tmfs_delay #(.W(3 * MED_ROOT_W), .DEPTH(MED_PAD)) u_med_dly (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({w_mr_a, w_mr_b, w_mr_c}), .o_q({w_med_a, w_med_b, w_med_c})
    );

    // area: root of the Heron product with the scale shifted out
    tmfs_isqrt #(.RAD_W(AREA_RAD_W)) u_area (
        .i_clk(i_clk), .i_en(w_en), .i_rad(AREA_RAD_W'(w_heron >> AREA_SH)),
        .o_root(w_area_root)
    );
    tmfs_delay #(.W(AREA_ROOT_W), .DEPTH(AREA_PAD)) u_area_pad (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_area_root), .o_q(w_area_pad)
    );
    tmfs_delay #(.W(AREA_ROOT_W), .DEPTH(QUO_W)) u_area_end (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_area_pad), .o_q(w_area_end)
    );

    // sides and pair sums wait for the divider inputs
    tmfs_delay #(.W(SB_W), .DEPTH(SIDE_DLY)) u_side_dly (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({r1_a, r1_b, r1_c, r1_sab, r1_sac, r1_sbc}),
        .o_q({w_sa, w_sb, w_sc, w_ssab, w_ssac, w_ssbc})
    );

    // heights: twice the area, rescaled, over each side
    assign w_hnum = {w_area_pad, {(FRAC_BITS + 1){1'b0}}};

    tmfs_div #(.NUM_W(HNUM_W), .DEN_W(SIDE_W), .QUO_W(QUO_W)) u_hgt_a (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_hnum), .i_den(w_sa), .o_quo(w_hgt_a)
    );
    tmfs_div #(.NUM_W(HNUM_W), .DEN_W(SIDE_W), .QUO_W(QUO_W)) u_hgt_b (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_hnum), .i_den(w_sb), .o_quo(w_hgt_b)
    );
    tmfs_div #(.NUM_W(HNUM_W), .DEN_W(SIDE_W), .QUO_W(QUO_W)) u_hgt_c (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_hnum), .i_den(w_sc), .o_quo(w_hgt_c)
    );

    // bisectors: root of s1*s2*x*y over s1+s2
    tmfs_isqrt #(.RAD_W(BIS_RAD_W)) u_bsq_a (
        .i_clk(i_clk), .i_en(w_en), .i_rad(BIS_RAD_W'(w_bn_a)), .o_root(w_br_a)
    );
    tmfs_isqrt #(.RAD_W(BIS_RAD_W)) u_bsq_b (
        .i_clk(i_clk), .i_en(w_en), .i_rad(BIS_RAD_W'(w_bn_b)), .o_root(w_br_b)
    );
    tmfs_isqrt #(.RAD_W(BIS_RAD_W)) u_bsq_c (
        .i_clk(i_clk), .i_en(w_en), .i_rad(BIS_RAD_W'(w_bn_c)), .o_root(w_br_c)
    );
    tmfs_div #(.NUM_W(BIS_ROOT_W), .DEN_W(SUM_W), .QUO_W(QUO_W)) u_bdv_a (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_br_a), .i_den(w_ssbc), .o_quo(w_bis_a)
    );
    tmfs_div #(.NUM_W(BIS_ROOT_W), .DEN_W(SUM_W), .QUO_W(QUO_W)) u_bdv_b (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_br_b), .i_den(w_ssac), .o_quo(w_bis_b)
    );
    tmfs_div #(.NUM_W(BIS_ROOT_W), .DEN_W(SUM_W), .QUO_W(QUO_W)) u_bdv_c (
        .i_clk(i_clk), .i_en(w_en), .i_num(w_br_c), .i_den(w_ssab), .o_quo(w_bis_c)
    );

    // status and perimeter ride alongside to the end
    tmfs_delay #(.W(STATUS_W + X_W), .DEPTH(STAT_DLY)) u_stat_dly (
        .i_clk(i_clk), .i_en(w_en),
        .i_d({r1_status, r1_x}), .o_q({w_status_end, w_perim_end})
    );

    // assemble the result, zero every metric on error
    always_comb begin
        w_final        = '0;
        w_final.status = w_status_end;
        if (w_status_end == tmfs_pkg::ST_OK) begin
            w_final.perimeter  = w_perim_end;
            w_final.area       = AREA_W'(w_area_end);
            w_final.height_a   = w_hgt_a;
            w_final.height_b   = w_hgt_b;
            w_final.height_c   = w_hgt_c;
            w_final.median_a   = w_med_a;
            w_final.median_b   = w_med_b;
            w_final.median_c   = w_med_c;
            w_final.bisector_a = w_bis_a;
            w_final.bisector_b = w_bis_b;
            w_final.bisector_c = w_bis_c;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], w_accept};
        end
    end

    // hold a refused result in the skid buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_out.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAT-1] && !o_out.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid <= w_final;
        end
    end

    // drive the output channel
    assign w_out = r_skid_vld ? r_skid : w_final;

    assign o_out.valid      = r_skid_vld || r_vld[LAT-1];
    assign o_out.status     = w_out.status;
    assign o_out.perimeter  = w_out.perimeter;
    assign o_out.area       = w_out.area;
    assign o_out.height_a   = w_out.height_a;
    assign o_out.height_b   = w_out.height_b;
    assign o_out.height_c   = w_out.height_c;
    assign o_out.median_a   = w_out.median_a;
    assign o_out.median_b   = w_out.median_b;
    assign o_out.median_c   = w_out.median_c;
    assign o_out.bisector_a = w_out.bisector_a;
    assign o_out.bisector_b = w_out.bisector_b;
    assign o_out.bisector_c = w_out.bisector_c;

endmodule

/* rtl/tmfs_delay.sv */
// Enabled shift-register delay line.
module tmfs_delay #(
    parameter int W     = 8,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_pipe [DEPTH];

    // advance all taps together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pipe[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_pipe[k] <= r_pipe[k-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];

endmodule

/* rtl/tmfs_wmul.sv */
// Two-stage wide multiplier built from four partial products.
module tmfs_wmul #(
    parameter int A_W = 68,
    parameter int B_W = 71
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [A_W-1:0]   i_a,
    input  logic [B_W-1:0]   i_b,
    output logic [A_W+B_W-1:0] o_p
);

    localparam int LO   = tmfs_pkg::SPLIT_W;
    localparam int AH_W = A_W - LO;
    localparam int BH_W = B_W - LO;
    localparam int HH_W = AH_W + BH_W;
    localparam int HL_W = AH_W + LO;
    localparam int LH_W = LO + BH_W;
    localparam int LL_W = 2 * LO;
    localparam int P_W  = A_W + B_W;

    logic [HH_W-1:0] r_hh;
    logic [HL_W-1:0] r_hl;
    logic [LH_W-1:0] r_lh;
    logic [LL_W-1:0] r_ll;
    logic [P_W-1:0]  r_p;

    // form partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hh <= HH_W'(i_a[A_W-1:LO]) * HH_W'(i_b[B_W-1:LO]);
            r_hl <= HL_W'(i_a[A_W-1:LO]) * HL_W'(i_b[LO-1:0]);
            r_lh <= LH_W'(i_a[LO-1:0]) * LH_W'(i_b[B_W-1:LO]);
            r_ll <= LL_W'(i_a[LO-1:0]) * LL_W'(i_b[LO-1:0]);
        end
    end

    // align and sum partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= (P_W'(r_hh) << (2 * LO)) + ((P_W'(r_hl) + P_W'(r_lh)) << LO)
                 + P_W'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

/* rtl/tmfs_isqrt.sv */
// Pipelined integer square root, one root bit per stage, truncating.
module tmfs_isqrt #(
    parameter int RAD_W = 68
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAD_W-1:0]     i_rad,
    output logic [RAD_W/2-1:0]   o_root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int CW     = RAD_W + 2;

    logic [RAD_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [RAD_W-1:0]  w_rem;
        logic [ROOT_W-1:0] w_root;
        logic [CW-1:0]     w_trial;
        logic              w_fit;
        logic [RAD_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign w_rem  = i_rad;
            assign w_root = '0;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
        end

        // try setting this root bit: (4q + 1) * 4^bit against the remainder
        always_comb begin
            w_trial = (CW'(w_root) << (2 * BIT + 2)) | (CW'(1) << (2 * BIT));
            w_fit   = CW'(w_rem) >= w_trial;
            n_rem   = w_fit ? RAD_W'(CW'(w_rem) - w_trial) : w_rem;
            n_root  = {w_root[ROOT_W-2:0], w_fit};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

/* rtl/tmfs_div.sv */
// Pipelined restoring divider, one quotient bit per stage, truncating.
module tmfs_div #(
    parameter int NUM_W = 70,
    parameter int DEN_W = 34,
    parameter int QUO_W = 34
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CW-1:0]    r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic [CW-1:0]    w_rem;
        logic [DEN_W-1:0] w_den;
        logic [QUO_W-1:0] w_quo;
        logic [CW-1:0]    w_trial;
        logic             w_fit;
        logic [CW-1:0]    n_rem;
        logic [QUO_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign w_rem = CW'(i_num);
            assign w_den = i_den;
            assign w_quo = '0;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_quo = r_quo[k-1];
        end

        // subtract the shifted divisor where it fits
        always_comb begin
            w_trial = CW'(w_den) << BIT;
            w_fit   = w_rem >= w_trial;
            n_rem   = w_fit ? w_rem - w_trial : w_rem;
            n_quo   = {w_quo[QUO_W-2:0], w_fit};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den;
                r_quo[k] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

/* rtl/tmfs_checker.sv */
// Port-level assertions on the result channel, bound to the top level.
module tmfs_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [tmfs_pkg::STATUS_W-1:0] i_status,
    input logic [tmfs_pkg::PERIM_W-1:0]  i_perimeter,
    input logic [tmfs_pkg::AREA_W-1:0]   i_area,
    input logic [tmfs_pkg::METRIC_W-1:0] i_height_a,
    input logic [tmfs_pkg::METRIC_W-1:0] i_median_a,
    input logic [tmfs_pkg::METRIC_W-1:0] i_bisector_a
);

    // a refused item stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result item dropped while stalled");

    // a refused item keeps its status, perimeter, area and median_a
    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_status) && $stable(i_perimeter)
                                && $stable(i_area) && $stable(i_median_a))
        else $error("result payload changed while stalled");

    // errors carry no metrics
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != tmfs_pkg::ST_OK) |-> (i_perimeter == '0) && (i_area == '0)
            && (i_height_a == '0) && (i_median_a == '0) && (i_bisector_a == '0))
        else $error("metrics not cleared on error status");

    // a valid triangle has a positive perimeter and median
    a_ok_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status == tmfs_pkg::ST_OK) |-> (i_perimeter != '0) && (i_median_a != '0))
        else $error("valid triangle with zero perimeter or median");

endmodule

bind triangle_metrics_from_sides tmfs_checker u_tmfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_out.valid),
    .i_ready      (o_out.ready),
    .i_status     (o_out.status),
    .i_perimeter  (o_out.perimeter),
    .i_area       (o_out.area),
    .i_height_a   (o_out.height_a),
    .i_median_a   (o_out.median_a),
    .i_bisector_a (o_out.bisector_a)
);

/* test/tb.sv */
// Self-checking testbench for the triangle metrics block.
`timescale 1ns / 100ps

module tb;

    localparam int FRAC       = 17;
    localparam int N_RANDOM   = 900;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN_WAIT = 150;
    localparam int SIDE_W     = tmfs_pkg::SIDE_W;
    localparam int PERIM_W    = tmfs_pkg::PERIM_W;
    localparam int AREA_W     = tmfs_pkg::AREA_W;
    localparam int METRIC_W   = tmfs_pkg::METRIC_W;
    localparam logic [63:0] SIDE_MIN = ((64'd1 << FRAC) + 64'd99999) / 64'd100000;
    localparam logic [63:0] SIDE_MAX = 64'd100000 << FRAC;

    typedef struct packed {
        logic [SIDE_W-1:0] a;
        logic [SIDE_W-1:0] b;
        logic [SIDE_W-1:0] c;
    } t_sides;

    logic i_clk;
    logic i_rst_n;

    tmfs_in_if  side_ch ();
    tmfs_out_if metric_ch ();

    triangle_metrics_from_sides #(.FRAC_BITS(FRAC)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (side_ch.sink),
        .o_out   (metric_ch.source)
    );

    t_sides            pending_sides[$];
    tmfs_pkg::t_result awaited_metrics[$];
    int      error_count;
    int      cycle_count;
    int      accepted_count;
    int      total_items;
    int      n_ok, n_range, n_shape;
    bit      side_taken;

    // Largest r with (r*m)^2 <= n, or r*m <= n when not squared
    function automatic logic [63:0] fit_root(logic [255:0] n, logic [63:0] m, bit squared);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [255:0] p;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            p = 256'(t) * 256'(m);
            if (squared)
                p = p * p;
            if (p <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] median_len(logic [63:0] opp, logic [63:0] s1,
                                               logic [63:0] s2);
        logic [255:0] q;
        q = 2 * (256'(s1) * 256'(s1) + 256'(s2) * 256'(s2)) - 256'(opp) * 256'(opp);
        return fit_root(q, 64'd2, 1'b1);
    endfunction

    function automatic logic [63:0] bisector_len(logic [63:0] s1, logic [63:0] s2,
                                                 logic [63:0] x, logic [63:0] y);
        return fit_root(256'(s1) * 256'(s2) * 256'(x) * 256'(y), s1 + s2, 1'b1);
    endfunction

    // Compute the expected metrics for one set of sides
    function automatic tmfs_pkg::t_result triangle_metrics(t_sides s);
        tmfs_pkg::t_result res;
        logic [63:0]  a, b, c, x, y, z, w, area;
        logic [255:0] twice_area;
        res = '0;
        a = 64'(s.a);
        b = 64'(s.b);
        c = 64'(s.c);
        if (a < SIDE_MIN || b < SIDE_MIN || c < SIDE_MIN ||
            a > SIDE_MAX || b > SIDE_MAX || c > SIDE_MAX) begin
            res.status = tmfs_pkg::ST_RANGE;
            return res;
        end
        if (a + b <= c || a + c <= b || b + c <= a) begin
            res.status = tmfs_pkg::ST_SHAPE;
            return res;
        end
        x = a + b + c;
        y = b + c - a;
        z = a + c - b;
        w = a + b - c;
        area = fit_root(256'(x) * 256'(y) * 256'(z) * 256'(w), 64'd1 << (FRAC + 2), 1'b1);
        twice_area = 256'(area) * (256'd2 << FRAC);
        res.status     = tmfs_pkg::ST_OK;
        res.perimeter  = x[PERIM_W-1:0];
        res.area       = area[AREA_W-1:0];
        res.height_a   = METRIC_W'(fit_root(twice_area, a, 1'b0));
        res.height_b   = METRIC_W'(fit_root(twice_area, b, 1'b0));
        res.height_c   = METRIC_W'(fit_root(twice_area, c, 1'b0));
        res.median_a   = METRIC_W'(median_len(a, b, c));
        res.median_b   = METRIC_W'(median_len(b, a, c));
        res.median_c   = METRIC_W'(median_len(c, a, b));
        res.bisector_a = METRIC_W'(bisector_len(b, c, x, y));
        res.bisector_b = METRIC_W'(bisector_len(a, c, x, z));
        res.bisector_c = METRIC_W'(bisector_len(a, b, x, w));
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                     exp_v, act_v);
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Side of random magnitude, kept inside the legal range
    function automatic logic [63:0] rand_side();
        logic [63:0] v;
        v = rand64() & ((64'd1 << $urandom_range(2, 34)) - 1);
        if (v < SIDE_MIN)
            v = SIDE_MIN;
        if (v > SIDE_MAX)
            v = SIDE_MAX;
        return v;
    endfunction

    function automatic void add_sides(logic [63:0] a, logic [63:0] b, logic [63:0] c);
        t_sides s;
        s.a = a[SIDE_W-1:0];
        s.b = b[SIDE_W-1:0];
        s.c = c[SIDE_W-1:0];
        pending_sides.push_back(s);
    endfunction

    // Idle percentages per phase: none, sender, receiver, both
    function automatic int send_idle_pct();
        int ph;
        ph = (accepted_count * 4) / (total_items + 1);
        return (ph == 1) ? 47 : (ph == 3) ? 32 : 0;
    endfunction

    function automatic int recv_stall_pct();
        int ph;
        ph = (accepted_count * 4) / (total_items + 1);
        return (ph == 2) ? 47 : (ph == 3) ? 32 : 0;
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Stimulus and end of run
    initial begin
        logic [63:0] a, b, c, lo, hi;
        int          pick;
        side_ch.valid    = 1'b0;
        side_ch.side_a   = '0;
        side_ch.side_b   = '0;
        side_ch.side_c   = '0;
        metric_ch.ready  = 1'b0;
        i_rst_n          = 1'b0;
        error_count      = 0;
        accepted_count   = 0;
        n_ok = 0; n_range = 0; n_shape = 0;

        // Directed: range edges, degenerate shapes, extremes
        add_sides(SIDE_MIN, SIDE_MIN, SIDE_MIN);
        add_sides(SIDE_MIN - 1, SIDE_MIN, SIDE_MIN);
        add_sides(SIDE_MIN, 0, SIDE_MIN);
        add_sides(SIDE_MIN, SIDE_MIN, 0);
        add_sides(SIDE_MAX, SIDE_MAX, SIDE_MAX);
        add_sides(SIDE_MAX + 1, SIDE_MAX, SIDE_MAX);
        add_sides(SIDE_MAX, SIDE_MAX + 1, SIDE_MAX);
        add_sides(SIDE_MAX, SIDE_MAX, 64'h3_FFFF_FFFF);
        add_sides(64'h3_FFFF_FFFF, 64'h3_FFFF_FFFF, 64'h3_FFFF_FFFF);
        add_sides(0, 0, 0);
        add_sides(3 << FRAC, 4 << FRAC, 5 << FRAC);
        add_sides(1 << FRAC, 2 << FRAC, 3 << FRAC);
        add_sides(5 << FRAC, 2 << FRAC, 3 << FRAC);
        add_sides(2 << FRAC, 5 << FRAC, 3 << FRAC);
        add_sides(1 << FRAC, 1 << FRAC, 3 << FRAC);
        add_sides(SIDE_MAX, SIDE_MAX, SIDE_MIN);
        add_sides(SIDE_MIN, SIDE_MAX, SIDE_MAX);
        add_sides(SIDE_MAX, SIDE_MIN, SIDE_MAX - 1);
        add_sides(SIDE_MAX, SIDE_MAX / 2, SIDE_MAX / 2);
        add_sides(SIDE_MAX, SIDE_MAX / 2, SIDE_MAX / 2 + 1);
        add_sides(64'h1_5555_5555, 64'h2_AAAA_AAAA, 64'h2_0000_0000);

        // Random: mostly valid triangles, some degenerate, some raw noise
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            a = rand_side();
            b = rand_side();
            if (pick < 10) begin
                add_sides(rand64(), rand64(), rand64());
            end else if (pick < 18) begin
                c = a + b;
                case ($urandom_range(0, 2))
                    0: add_sides(a, b, c);
                    1: add_sides(c, a, b);
                    default: add_sides(a, c, b);
                endcase
            end else begin
                lo = (a > b) ? a - b + 1 : b - a + 1;
                hi = a + b - 1;
                if (hi > SIDE_MAX)
                    hi = SIDE_MAX;
                c = lo + rand64() % (hi - lo + 1);
                add_sides(a, b, c);
            end
        end
        total_items = pending_sides.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain: wait for all items to be taken and all results to arrive
        wait (pending_sides.size() == 0 && !side_ch.valid && awaited_metrics.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d triangles: %0d valid, %0d out of range, %0d degenerate.",
                 accepted_count, n_ok, n_range, n_shape);
        $display("Idle phases covered: none, sender gaps, receiver stalls, both.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Sample handshakes and check results on the rising edge
    always @(posedge i_clk) begin
        tmfs_pkg::t_result got, want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        side_taken = i_rst_n && side_ch.valid && side_ch.ready;
        if (side_taken) begin
            want = triangle_metrics({side_ch.side_a, side_ch.side_b, side_ch.side_c});
            awaited_metrics.push_back(want);
            accepted_count++;
            case (want.status)
                tmfs_pkg::ST_OK:    n_ok++;
                tmfs_pkg::ST_RANGE: n_range++;
                default:            n_shape++;
            endcase
        end
        if (i_rst_n && metric_ch.valid && metric_ch.ready) begin
            got = {metric_ch.status, metric_ch.perimeter, metric_ch.area,
                   metric_ch.height_a, metric_ch.height_b, metric_ch.height_c,
                   metric_ch.median_a, metric_ch.median_b, metric_ch.median_c,
                   metric_ch.bisector_a, metric_ch.bisector_b, metric_ch.bisector_c};
            if (awaited_metrics.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result item, expected none, actual status %0d",
                         $realtime, got.status);
            end else begin
                want = awaited_metrics.pop_front();
                check_field("status",     64'(want.status),     64'(got.status));
                check_field("perimeter",  64'(want.perimeter),  64'(got.perimeter));
                check_field("area",       64'(want.area),       64'(got.area));
                check_field("height_a",   64'(want.height_a),   64'(got.height_a));
                check_field("height_b",   64'(want.height_b),   64'(got.height_b));
                check_field("height_c",   64'(want.height_c),   64'(got.height_c));
                check_field("median_a",   64'(want.median_a),   64'(got.median_a));
                check_field("median_b",   64'(want.median_b),   64'(got.median_b));
                check_field("median_c",   64'(want.median_c),   64'(got.median_c));
                check_field("bisector_a", 64'(want.bisector_a), 64'(got.bisector_a));
                check_field("bisector_b", 64'(want.bisector_b), 64'(got.bisector_b));
                check_field("bisector_c", 64'(want.bisector_c), 64'(got.bisector_c));
            end
        end
    end

    initial cycle_count = 0;

    // Drive side items and the result ready on the falling edge
    always @(negedge i_clk) begin
        t_sides s;
        if (i_rst_n) begin
            // advance to a new item once the current one was taken, or fill an empty slot
            if (!side_ch.valid || side_taken) begin
                if (pending_sides.size() > 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                    s = pending_sides.pop_front();
                    side_ch.side_a <= s.a;
                    side_ch.side_b <= s.b;
                    side_ch.side_c <= s.c;
                    side_ch.valid  <= 1'b1;
                end else begin
                    side_ch.valid <= 1'b0;
                end
            end
            metric_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct());
            side_taken = 1'b0;
        end
    end

endmodule

/* files.f */
rtl/tmfs_pkg.sv
rtl/tmfs_if.sv
rtl/tmfs_delay.sv
rtl/tmfs_wmul.sv
rtl/tmfs_isqrt.sv
rtl/tmfs_div.sv
rtl/triangle_metrics_from_sides.sv
rtl/tmfs_checker.sv
test/tb.sv
